// ===== rtl/core/ptts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

    localparam int NUM_TASKS_DEFAULT = 16;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CREATE  = 2'd1;
    localparam logic [1:0] KIND_SUSPEND = 2'd2;
    localparam logic [1:0] KIND_RESUME  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  task_id;
        logic [15:0] period;
        logic [15:0] first_delay;
        logic        start_ready;
    } cmd_t;

    typedef struct packed {
        logic [3:0] fired_task;
        logic       last_fired;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic cmd_accept;
        logic scan_init;
        logic scan_issue;
        logic flush;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic last_idx;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ptts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         kind,
    input  wire ptts_pkg::status_t  status,
    output ptts_pkg::ctrl_t         ctl,
    output logic                    busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.cmd_accept = start && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (kind == ptts_pkg::KIND_TICK))
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue one slot read per cycle
                ctl.scan_issue = 1'b1;
                if (status.last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ptts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptts_datapath #(
    parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptts_pkg::cmd_t     cmd,
    input  wire ptts_pkg::ctrl_t    ctl,
    output ptts_pkg::status_t       status,
    output ptts_pkg::res_t          result,
    output logic                    result_valid
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    logic [NUM_TASKS-1:0] present_reg;
    logic [NUM_TASKS-1:0] present_next;
    logic [NUM_TASKS-1:0] ready_reg;
    logic [NUM_TASKS-1:0] ready_next;

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          s1_valid_reg;
    logic [IW-1:0] s1_idx_reg;

    logic          pend_valid_reg;
    logic          pend_valid_next;
    logic [3:0]    pend_idx_reg;
    logic [3:0]    pend_idx_next;

    logic           result_valid_reg;
    logic           result_valid_next;
    ptts_pkg::res_t result_reg;
    ptts_pkg::res_t result_next;

    logic          id_ok;
    logic [IW-1:0] cmd_idx;
    logic          do_create;
    logic          do_suspend;
    logic          do_resume;

    logic [15:0]   cd_rdata;
    logic [15:0]   per_rdata;
    logic          s1_active;
    logic          s1_fire;
    logic [15:0]   s1_wb;

    logic          cd_we;
    logic [IW-1:0] cd_waddr;
    logic [15:0]   cd_wdata;

    // command decode; ids beyond the table are dropped
    assign id_ok      = (32'(cmd.task_id) < NUM_TASKS);
    assign cmd_idx    = IW'(cmd.task_id);
    assign do_create  = ctl.cmd_accept && id_ok && (cmd.kind == ptts_pkg::KIND_CREATE);
    assign do_suspend = ctl.cmd_accept && id_ok && (cmd.kind == ptts_pkg::KIND_SUSPEND);
    assign do_resume  = ctl.cmd_accept && id_ok && (cmd.kind == ptts_pkg::KIND_RESUME);

    always_comb
    begin
        present_next = present_reg;
        ready_next   = ready_reg;
        if (do_create)
        begin
            present_next[cmd_idx] = 1'b1;
            ready_next[cmd_idx]   = cmd.start_ready;
        end
        if (do_suspend)
        begin
            ready_next[cmd_idx] = 1'b0;
        end
        if (do_resume)
        begin
            ready_next[cmd_idx] = 1'b1;
        end
    end

    // scan counter
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.scan_init)
        begin
            idx_next = '0;
        end
        else if (ctl.scan_issue)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    assign status.last_idx = (idx_reg == IW'(NUM_TASKS - 1));

    // slot update, in the cycle after its read
    assign s1_active = s1_valid_reg && present_reg[s1_idx_reg] && ready_reg[s1_idx_reg];
    assign s1_fire   = s1_active && (cd_rdata == 16'd0);
    assign s1_wb     = s1_fire ? (per_rdata - 16'd1) : (cd_rdata - 16'd1);

    assign cd_we    = do_create || s1_active;
    assign cd_waddr = do_create ? cmd_idx : s1_idx_reg;
    assign cd_wdata = do_create ? cmd.first_delay : s1_wb;

    ptts_ram #(
        .WIDTH (16),
        .DEPTH (NUM_TASKS)
    ) u_period_ram (
        .clk   (clk),
        .we    (do_create),
        .waddr (cmd_idx),
        .wdata (cmd.period),
        .raddr (idx_reg),
        .rdata (per_rdata)
    );

    ptts_ram #(
        .WIDTH (16),
        .DEPTH (NUM_TASKS)
    ) u_countdown_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (cd_waddr),
        .wdata (cd_wdata),
        .raddr (idx_reg),
        .rdata (cd_rdata)
    );

    // hold one fired slot back until the next firing or the end of the scan
    always_comb
    begin
        pend_valid_next        = pend_valid_reg;
        pend_idx_next          = pend_idx_reg;
        result_valid_next      = 1'b0;
        result_next.fired_task = pend_idx_reg;
        result_next.last_fired = ctl.flush;
        if (s1_fire)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b1;
            pend_idx_next     = 4'(s1_idx_reg);
        end
        else if (ctl.flush)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg      <= '0;
            ready_reg        <= '0;
            idx_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            present_reg      <= present_next;
            ready_reg        <= ready_next;
            idx_reg          <= idx_next;
            s1_valid_reg     <= ctl.scan_issue;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= idx_reg;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Periodic task tick scheduler.
//
// Command channel: present a transaction on cmd and raise start; it is taken at the
// rising edge where start is high and busy is low. Create, suspend and resume
// complete in that single cycle and busy stays low, so one may follow every cycle.
// A tick raises busy while the scan reads one slot per cycle through the single
// read port of the period and countdown memories, updates it in the cycle after,
// then drains and flushes.
// Result channel: each fired slot appears on result for exactly one cycle with
// result_valid high. One firing is held back until the next is found, so
// last_fired can mark the final one; the last result of a tick leaves in the cycle
// in which busy falls. Ticks with nothing due produce no transaction.
// The receiver cannot stall; results are never held.
// Reset clears every present and ready bit and returns the controller to idle;
// the period and countdown memories need no clearing since the data read from
// slots that were never created is ignored.

module periodic_task_tick_scheduler #(
    parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ptts_pkg::cmd_t  cmd,
    output logic                 busy,
    output ptts_pkg::res_t       result,
    output logic                 result_valid
);

    ptts_pkg::ctrl_t   ctl;
    ptts_pkg::status_t status;

    // sequence the scan
    ptts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (cmd.kind),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    // slot table, update arithmetic and result register
    ptts_datapath #(
        .NUM_TASKS (NUM_TASKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctl          (ctl),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // a marked last result closes the tick: nothing follows directly
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_fired) |=> !result_valid)
        else $error("result directly after last_fired");

    // create, suspend and resume never occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.kind != ptts_pkg::KIND_TICK)) |=> !busy)
        else $error("busy raised by a non-tick command");

    // an accepted tick always starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.kind == ptts_pkg::KIND_TICK)) |=> busy)
        else $error("tick accepted without starting a scan");

endmodule

`default_nettype wire
